[design/fwhc_pkg.sv]
// Shared types, codes and constants for the firmware header checker.
package fwhc_pkg;

	localparam int unsigned NUM_ENTRIES_MAX = 4;
	localparam int unsigned TABLE_ENTRIES_DEFAULT = 4;
	localparam int unsigned HEADER_LEN = 8;

	localparam logic [31:0] MODEL_LIMIT = 32'd150;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	// Configuration register indexes
	localparam logic [3:0] REG_TAG_BASE = 4'd0;
	localparam logic [3:0] REG_MODEL_BASE = 4'd4;

	localparam logic [31:0] TAG_RESET [NUM_ENTRIES_MAX] = '{
		32'h7A656E76, 32'h7A6D6F7A, 32'h7A656E00, 32'h7A786669
	};
	localparam logic [7:0] MODEL_RESET [NUM_ENTRIES_MAX] = '{
		8'd85, 8'd87, 8'd90, 8'd86
	};

	typedef enum logic [1:0] {
		VERDICT_RAW       = 2'd0,
		VERDICT_KNOWN     = 2'd1,
		VERDICT_PLAUSIBLE = 2'd2,
		VERDICT_STRANGE   = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} img_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [1:0]  player_index;
		logic [31:0] implied_model;
	} res_t;

	function automatic logic is_printable(input logic [7:0] c);
		return (c >= PRINT_LO) && (c <= PRINT_HI);
	endfunction

endpackage

[design/fwhc_judge.sv]
// Verdict logic: tag lookup, checksum check and printable-tag classification.
module fwhc_judge import fwhc_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
	input  logic [63:0]                    header,
	input  logic [31:0]                    sum,
	input  logic                           full,
	input  logic [TABLE_ENTRIES-1:0][31:0] tags,
	input  logic [TABLE_ENTRIES-1:0][7:0]  models,
	output res_t                           res
);

	logic [31:0] checksum;
	logic [31:0] tag;
	logic [31:0] implied;
	logic        hit;
	logic [1:0]  hit_idx;
	logic [7:0]  hit_model;
	logic        plausible_tag;

	assign checksum = header[63:32];
	assign tag      = header[31:0];
	assign implied  = checksum - sum;

	// first matching entry wins: scan from the top so lower entries override
	always_comb begin
		hit       = 1'b0;
		hit_idx   = '0;
		hit_model = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (tags[i] == tag) begin
				hit       = 1'b1;
				hit_idx   = 2'(i);
				hit_model = models[i];
			end
		end
	end

	assign plausible_tag = is_printable(tag[31:24]) && is_printable(tag[23:16]) &&
		is_printable(tag[15:8]) && (is_printable(tag[7:0]) || tag[7:0] == 8'h00);

	// model + sum == checksum is the same as implied == model
	always_comb begin
		res.verdict       = VERDICT_RAW;
		res.player_index  = '0;
		res.implied_model = '0;
		if (full) begin
			res.implied_model = implied;
			if (hit && implied == {24'd0, hit_model}) begin
				res.verdict      = VERDICT_KNOWN;
				res.player_index = hit_idx;
			end else if (plausible_tag) begin
				res.verdict = (implied < MODEL_LIMIT) ? VERDICT_PLAUSIBLE : VERDICT_STRANGE;
			end
		end
	end

endmodule

[design/firmware_header_checker.sv]
// Top level of the firmware header checker: byte intake, header/sum state, result register.
// Path: the result of a last byte passes the input register, then the result register, and is
//   valid on res once the result register holds it; res_stall can hold the byte in the first.
// Throughput: one byte per cycle; img_stall rises only when a last byte sits in the
//   input register while the result register holds a result that res_stall keeps.
// Reset (arst_n low, asynchronous): stream state cleared, both stages empty, tags and
//   model numbers back to their default table.
module firmware_header_checker import fwhc_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        img_valid,
	output logic        img_stall,
	input  img_t        img,
	// verdict stream
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	// configuration writes
	input  logic        cfg_write,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration table
	logic [TABLE_ENTRIES-1:0][31:0] tag_q;
	logic [TABLE_ENTRIES-1:0][7:0]  model_q;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_q[i]   <= TAG_RESET[i];
				model_q[i] <= MODEL_RESET[i];
			end else begin
				if (cfg_write && cfg_index == REG_TAG_BASE + 4'(i)) begin
					tag_q[i] <= cfg_data;
				end
				if (cfg_write && cfg_index == REG_MODEL_BASE + 4'(i)) begin
					model_q[i] <= cfg_data[7:0];
				end
			end
		end
	end

	// Input register
	img_t item_s1;
	logic item_valid_s1;
	logic s1_go;
	logic img_take;
	logic res_valid_q;

	// A non-last byte only touches the stream state and never waits on the result
	// side. A last byte needs the result register free or draining this cycle.
	assign s1_go     = item_valid_s1 && (!item_s1.last_byte || !res_valid_q || !res_stall);
	assign img_stall = item_valid_s1 && !s1_go;
	assign img_take  = img_valid && !img_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (img_take) begin
			item_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (img_take) begin
			item_s1 <= img;
		end
	end

	// Stream state: header bytes, saturating header count, payload sum
	logic [63:0] header_q, header_n;
	logic [3:0]  count_q, count_n;
	logic [31:0] sum_q, sum_n;
	logic        in_header;
	logic        full_n;

	assign in_header = (count_q < 4'(HEADER_LEN));

	always_comb begin
		header_n = header_q;
		count_n  = count_q;
		sum_n    = sum_q;
		if (in_header) begin
			// byte 0 lands in the top lane
			for (int k = 0; k < HEADER_LEN; k++) begin
				if (count_q[2:0] == 3'(k)) begin
					header_n[63 - 8*k -: 8] = item_s1.data_byte;
				end
			end
			count_n = count_q + 4'd1;
		end else begin
			sum_n = sum_q + {24'd0, item_s1.data_byte};
		end
	end

	assign full_n = (count_n == 4'(HEADER_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
		end else if (s1_go) begin
			if (item_s1.last_byte) begin
				// end of image: next byte starts a fresh header
				header_q <= '0;
				count_q  <= '0;
				sum_q    <= '0;
			end else begin
				header_q <= header_n;
				count_q  <= count_n;
				sum_q    <= sum_n;
			end
		end
	end

	// Verdict
	res_t verdict_n;

	fwhc_judge #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_judge (
		.header(header_n),
		.sum   (sum_n),
		.full  (full_n),
		.tags  (tag_q),
		.models(model_q),
		.res   (verdict_n)
	);

	// Result register
	res_t res_q;
	logic res_load;

	assign res_load = s1_go && item_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= verdict_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(HEADER_LEN))
		else $error("header count beyond header length");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (count_q == '0 && sum_q == '0 && header_q == '0))
		else $error("stream state not cleared after last byte");

	a_index_only_known: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.verdict != VERDICT_KNOWN |-> res.player_index == '0)
		else $error("player index set on a non-known verdict");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid_s1 && item_s1.last_byte))
		else $error("result appeared without a last byte");

	a_short_is_raw: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && !full_n |=> res.verdict == VERDICT_RAW && res.implied_model == '0)
		else $error("short image not reported raw");

endmodule
